/* hdl/ovl_pkg.sv */
// Shared types and constants for the ordered value list.
`default_nettype none
package ovl_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_DUMP_FWD = 3'd2;
  localparam logic [OP_W-1:0] OP_DUMP_REV = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  // Port controls from the sequencer to the entry memory
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage
`default_nettype wire

/* hdl/ovl_mem.sv */
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module ovl_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                        clk,
  input  wire ovl_pkg::mem_ctl_t           ctl,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [ovl_pkg::DATA_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output      logic [ovl_pkg::DATA_W-1:0]  rdata
);
  import ovl_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/ovl_ctrl.sv */
// Sequencer: command decode, list walks over the memory, result registers.
`default_nettype none
module ovl_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [ovl_pkg::OP_W-1:0]          op,
  input  wire logic signed [ovl_pkg::DATA_W-1:0] value,
  output      logic                              strobe,
  output      logic signed [ovl_pkg::DATA_W-1:0] value_out,
  output      logic [ovl_pkg::CNT_W-1:0]         count,
  output      logic                              last,
  output      logic [ovl_pkg::STAT_W-1:0]        status,
  output      ovl_pkg::mem_ctl_t                 mem_ctl,
  output      logic [AW-1:0]                     mem_waddr,
  output      logic [ovl_pkg::DATA_W-1:0]        mem_wdata,
  output      logic [AW-1:0]                     mem_raddr,
  input  wire logic [ovl_pkg::DATA_W-1:0]        mem_rdata
);
  import ovl_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t            state, state_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [CNT_W-1:0]  issue_q, issue_next;
  logic [CNT_W-1:0]  wr_q, wr_next;
  logic [CNT_W-1:0]  n_q;
  logic              pend, pend_next;
  logic              pend_last, pend_last_next;
  logic              is_remove_q, is_rev_q;
  logic [DATA_W-1:0] val_q;

  logic              accept, issue, keep;
  logic [CNT_W-1:0]  raddr_full;

  logic              res_v;
  logic [DATA_W-1:0] res_val;
  logic [CNT_W-1:0]  res_cnt;
  logic              res_last;
  logic [STAT_W-1:0] res_stat;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign issue  = (state == S_WALK) && (issue_q < n_q);
  assign keep   = pend && is_remove_q && (mem_rdata != val_q);

  assign raddr_full = is_rev_q ? (n_q - CNT_W'(1) - issue_q) : issue_q;
  assign mem_raddr  = raddr_full[AW-1:0];

  // Append writes in idle; compaction writes survivors during a remove walk
  assign mem_ctl.re = issue;
  assign mem_ctl.we = (accept && (op == OP_APPEND) && (entry_count < DEPTH_C)) || keep;
  assign mem_waddr  = (state == S_IDLE) ? entry_count[AW-1:0] : wr_q[AW-1:0];
  assign mem_wdata  = (state == S_IDLE) ? value : mem_rdata;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    issue_next       = issue_q;
    wr_next          = wr_q;
    pend_next        = 1'b0;
    pend_last_next   = 1'b0;
    res_v            = 1'b0;
    res_val          = '0;
    res_cnt          = entry_count;
    res_last         = 1'b1;
    res_stat         = STAT_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          res_v = 1'b1;
          case (op)
            OP_APPEND: begin
              if (entry_count >= DEPTH_C) begin
                res_stat = STAT_FULL;
              end else begin
                entry_count_next = entry_count + CNT_W'(1);
                res_cnt          = entry_count_next;
              end
            end
            OP_REMOVE, OP_DUMP_FWD, OP_DUMP_REV: begin
              if (entry_count == '0) begin
                res_stat = STAT_EMPTY;
              end else begin
                res_v      = 1'b0;
                state_next = S_WALK;
                issue_next = '0;
                wr_next    = '0;
              end
            end
            OP_CLEAR: begin
              entry_count_next = '0;
              res_cnt          = '0;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (issue) begin
          issue_next     = issue_q + CNT_W'(1);
          pend_next      = 1'b1;
          pend_last_next = (issue_next == n_q);
        end
        if (pend) begin
          if (is_remove_q) begin
            if (keep) begin
              wr_next = wr_q + CNT_W'(1);
            end
            if (pend_last) begin
              entry_count_next = wr_next;
              res_v            = 1'b1;
              res_cnt          = wr_next;
              state_next       = S_IDLE;
            end
          end else begin
            res_v    = 1'b1;
            res_val  = mem_rdata;
            res_last = pend_last;
            if (pend_last) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      issue_q     <= '0;
      wr_q        <= '0;
      n_q         <= '0;
      pend        <= 1'b0;
      pend_last   <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      issue_q     <= issue_next;
      wr_q        <= wr_next;
      pend        <= pend_next;
      pend_last   <= pend_last_next;
      strobe      <= res_v;
      if (accept) begin
        n_q <= entry_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_remove_q <= (op == OP_REMOVE);
      is_rev_q    <= (op == OP_DUMP_REV);
      val_q       <= value;
    end
    value_out <= res_val;
    count     <= res_cnt;
    last      <= res_last;
    status    <= res_stat;
  end

  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == S_WALK)
    else $error("read data pending outside a walk");

  a_writer_behind: assert property (@(posedge clk) disable iff (rst)
    wr_q <= issue_q)
    else $error("compaction pointer overtook the read pointer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> issue_q <= n_q)
    else $error("walk read past list end");

  a_mid_result: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> state == S_WALK)
    else $error("non-final result outside a dump walk");

endmodule
`default_nettype wire

/* hdl/ordered_value_list.sv */
// Top level of the ordered value list: sequencer plus entry memory.
//
// Usage: drive op and value and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. Results appear on
// value_out/count/last/status for exactly one cycle, marked by strobe; the
// receiver cannot stall, so every strobe must be captured when it shows.
// Append, clear, unknown ops and remove/dump of an empty list give one result,
// registered in the cycle after the transaction, and busy stays low, so such
// transactions may follow every cycle.
// Remove and dump walk the stored entries through the memory read port, one
// entry per cycle: the first dump result passes the memory read data register
// and then the result registers, and the rest follow each cycle; a remove gives
// its single result once its last entry has been read. busy stays high for the
// whole walk, since the single memory read port must read every entry.
// Reset (rst, synchronous) empties the list; memory contents are not cleared
// since no entry is read before it is written.
`default_nettype none
module ordered_value_list #(
  parameter int DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [ovl_pkg::OP_W-1:0]          op,
  input  wire logic signed [ovl_pkg::DATA_W-1:0] value,
  output      logic                              strobe,
  output      logic signed [ovl_pkg::DATA_W-1:0] value_out,
  output      logic [ovl_pkg::CNT_W-1:0]         count,
  output      logic                              last,
  output      logic [ovl_pkg::STAT_W-1:0]        status
);
  import ovl_pkg::*;

  // Address width, held to at least one bit for a single-entry list
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  // Command decode, walk sequencing and result registers
  ovl_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .value     (value),
    .strobe    (strobe),
    .value_out (value_out),
    .count     (count),
    .last      (last),
    .status    (status),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry storage, head at address zero
  ovl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

/* verif/ordered_value_list_test.sv */
// Self-checking testbench for the ordered value list: directed table, full-list fill, random mix.
module ordered_value_list_test;
  import ovl_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int RANDOM_ITEMS = 110;

  // Op codes the block does not define; it answers them with a plain status.
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  // One result as the block presents it on its output ports.
  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic [CNT_W-1:0]         count;
    logic                     last;
    logic [STAT_W-1:0]        status;
  } result_t;

  // One row of the directed table. When typed is set, the single result of the
  // row is known up front: value_out 0, last 1, and the count and status below.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    logic [CNT_W-1:0]         count;
    logic [STAT_W-1:0]        status;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic                     strobe;
  logic signed [DATA_W-1:0] value_out;
  logic [CNT_W-1:0]         count;
  logic                     last;
  logic [STAT_W-1:0]        status;

  // Shadow copy of the list contents, head at index 0.
  logic signed [DATA_W-1:0] list_mirror[$];
  // Results still owed by the block, oldest first.
  result_t                  pending_results[$];
  stim_row_t                directed_rows[$];

  int mismatch_count = 0;
  int results_checked = 0;
  int transactions_sent = 0;
  int full_drops = 0;
  int peak_entries = 0;
  int burst_left = 0;

  ordered_value_list #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .value(value),
    .strobe(strobe),
    .value_out(value_out),
    .count(count),
    .last(last),
    .status(status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one transaction to the shadow list and queue every result it owes.
  function automatic void predict_list_op(input logic [OP_W-1:0] cmd,
                                          input logic signed [DATA_W-1:0] operand);
    result_t r;
    logic signed [DATA_W-1:0] kept[$];
    int n;
    n = list_mirror.size();
    r = '0;
    r.last = 1'b1;
    r.status = STAT_OK;
    case (cmd)
      OP_APPEND: begin
        if (n >= LIST_DEPTH) begin
          // Full list: drop the value, leave the list alone.
          r.status = STAT_FULL;
          full_drops++;
        end else begin
          list_mirror.push_back(operand);
          if (list_mirror.size() > peak_entries) peak_entries = list_mirror.size();
        end
      end
      OP_REMOVE: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // Keep survivors in their original order.
          foreach (list_mirror[i]) begin
            if (list_mirror[i] !== operand) kept.push_back(list_mirror[i]);
          end
          list_mirror = kept;
        end
      end
      OP_DUMP_FWD, OP_DUMP_REV: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // One result per entry; the final one carries last.
          for (int i = 0; i < n; i++) begin
            r.count = CNT_W'(n);
            r.value_out = (cmd == OP_DUMP_FWD) ? list_mirror[i] : list_mirror[n - 1 - i];
            r.last = (i == n - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      OP_CLEAR: list_mirror.delete();
      default: ;
    endcase
    r.count = CNT_W'(list_mirror.size());
    pending_results.push_back(r);
  endfunction

  // Favor a small pool of values so removes find matches; the rest is random.
  function automatic logic signed [DATA_W-1:0] pick_operand();
    logic signed [DATA_W-1:0] pool[8];
    pool = '{32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5, -32'sd5, 32'sd100};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic stim_row_t mk_row(input logic [OP_W-1:0] cmd,
                                       input logic signed [DATA_W-1:0] operand,
                                       input bit typed,
                                       input int want_count,
                                       input logic [STAT_W-1:0] want_status);
    stim_row_t r;
    r.op = cmd;
    r.value = operand;
    r.typed = typed;
    r.count = CNT_W'(want_count);
    r.status = want_status;
    return r;
  endfunction

  // Drive one transaction. Entered and left at a falling edge.
  task automatic send_item(input logic [OP_W-1:0] cmd,
                           input logic signed [DATA_W-1:0] operand,
                           input bit typed,
                           input logic [CNT_W-1:0] want_count,
                           input logic [STAT_W-1:0] want_status);
    int gap;
    result_t want;
    // Alternate between back-to-back bursts and random idle gaps.
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(5, 20);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 7);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op <= cmd;
    value <= operand;
    start <= 1'b1;
    // Hold the transaction until the block takes it.
    do @(posedge clk); while (busy);
    transactions_sent++;
    predict_list_op(cmd, operand);
    if (typed) begin
      // Swap in the hand-written expectation for this single-result row.
      want = '0;
      want.count = want_count;
      want.last = 1'b1;
      want.status = want_status;
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
    @(negedge clk);
  endtask

  // Check every strobed result against the oldest one still owed.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && strobe) begin
      got.value_out = value_out;
      got.count = count;
      got.last = last;
      got.status = status;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing owed: value_out=%0d count=%0d last=%0d status=%0d",
                   $realtime, got.value_out, got.count, got.last, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected value_out=%0d count=%0d last=%0d status=%0d, %s",
                     $realtime, want.value_out, want.count, want.last, want.status,
                     $sformatf("got value_out=%0d count=%0d last=%0d status=%0d",
                               got.value_out, got.count, got.last, got.status));
        end
      end
    end
  end

  initial begin
    logic [OP_W-1:0] cmd;
    logic signed [DATA_W-1:0] operand;
    int pick;

    rst = 1'b1;
    start = 1'b0;
    op = OP_APPEND;
    value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: empty-list cases, value extremes, every op, reserved ops.
    directed_rows.push_back(mk_row(OP_DUMP_FWD, 0, 1'b1, 0, STAT_EMPTY));
    directed_rows.push_back(mk_row(OP_REMOVE, 7, 1'b1, 0, STAT_EMPTY));
    directed_rows.push_back(mk_row(OP_DUMP_REV, 0, 1'b1, 0, STAT_EMPTY));
    directed_rows.push_back(mk_row(OP_APPEND, 32'sh7FFF_FFFF, 1'b1, 1, STAT_OK));
    directed_rows.push_back(mk_row(OP_APPEND, 32'sh8000_0000, 1'b1, 2, STAT_OK));
    directed_rows.push_back(mk_row(OP_APPEND, 0, 1'b1, 3, STAT_OK));
    directed_rows.push_back(mk_row(OP_APPEND, -1, 1'b1, 4, STAT_OK));
    directed_rows.push_back(mk_row(OP_APPEND, 32'sh7FFF_FFFF, 1'b1, 5, STAT_OK));
    directed_rows.push_back(mk_row(OP_DUMP_FWD, 0, 1'b0, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_DUMP_REV, -1, 1'b0, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_REMOVE, 12345, 1'b1, 5, STAT_OK));
    directed_rows.push_back(mk_row(OP_REMOVE, 32'sh7FFF_FFFF, 1'b0, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_DUMP_FWD, 0, 1'b0, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_RSVD_LO, 0, 1'b1, 3, STAT_OK));
    directed_rows.push_back(mk_row(OP_RSVD_MID, 32'sh5555_AAAA, 1'b1, 3, STAT_OK));
    directed_rows.push_back(mk_row(OP_RSVD_HI, -1, 1'b1, 3, STAT_OK));
    directed_rows.push_back(mk_row(OP_REMOVE, 32'sh8000_0000, 1'b0, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_DUMP_REV, 0, 1'b0, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_CLEAR, 0, 1'b1, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_CLEAR, -1, 1'b1, 0, STAT_OK));
    directed_rows.push_back(mk_row(OP_REMOVE, 0, 1'b1, 0, STAT_EMPTY));
    directed_rows.push_back(mk_row(OP_DUMP_FWD, 0, 1'b1, 0, STAT_EMPTY));
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].count, directed_rows[i].status);

    // Fill to capacity, push past it, then walk and trim the full list.
    while (list_mirror.size() < LIST_DEPTH) send_item(OP_APPEND, pick_operand(), 1'b0, '0, '0);
    send_item(OP_APPEND, pick_operand(), 1'b1, CNT_W'(LIST_DEPTH), STAT_FULL);
    send_item(OP_APPEND, 32'sh8000_0000, 1'b1, CNT_W'(LIST_DEPTH), STAT_FULL);
    send_item(OP_DUMP_FWD, 0, 1'b0, '0, '0);
    send_item(OP_DUMP_REV, 0, 1'b0, '0, '0);
    send_item(OP_REMOVE, list_mirror[0], 1'b0, '0, '0);
    send_item(OP_DUMP_FWD, 0, 1'b0, '0, '0);

    // Random mix, append-heavy so the list keeps growing toward full.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      operand = pick_operand();
      if (pick < 50 || pick >= 95) begin
        cmd = OP_APPEND;
      end else if (pick < 65) begin
        cmd = OP_REMOVE;
        // Aim half the removes at a value known to be stored.
        if (list_mirror.size() != 0 && $urandom_range(0, 1) == 1)
          operand = list_mirror[$urandom_range(0, list_mirror.size() - 1)];
      end else if (pick < 75) begin
        cmd = OP_DUMP_FWD;
      end else if (pick < 85) begin
        cmd = OP_DUMP_REV;
      end else if (pick < 90) begin
        cmd = OP_CLEAR;
      end else begin
        cmd = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      end
      send_item(cmd, operand, 1'b0, '0, '0);
    end
    start <= 1'b0;

    // Drain everything owed, then give a full walk's time for stray strobes.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);

    $display("Ran %0d transactions, checked %0d results, %0d mismatches.",
             transactions_sent, results_checked, mismatch_count);
    $display("List peaked at %0d entries; %0d appends refused on a full list.",
             peak_entries, full_drops);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
